// ===== src/ntcadc_pkg.sv =====
// Shared constants, types and helper functions for the NTC thermistor converter.
// Used by ntc_adc_to_temperature and its port checker; depends on nothing.
`default_nettype none

package ntcadc_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int CFG_W        = 20;
	localparam int CFG_IDX_W    = 2;
	localparam int TEMP_W       = 19;
	localparam int OUT_TDATA_W  = 24;

	localparam logic [13:0] BETA_RST    = 14'd3435;
	localparam logic [19:0] PULLUP_RST  = 20'd10000;
	localparam logic [19:0] NOMINAL_RST = 20'd10000;
	localparam logic [15:0] NOM_CK_RST  = 16'd29815;

	// ln(2) in Q32
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic signed [TEMP_W-1:0] FAULT_TEMP = -19'sd99900;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 19'sd200000;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -19'sd27315;
	localparam logic [17:0] ZERO_C_CK = 18'd27315;
	localparam logic [17:0] TCK_MAX   = 18'd227315;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BETA    = 2'd0,
		REG_PULLUP  = 2'd1,
		REG_NOMINAL = 2'd2,
		REG_NOM_CK  = 2'd3
	} cfg_reg_t;

	// Position of the leading one, 0 for inputs of 0 or 1.
	function automatic logic [4:0] msb_pos(input logic [19:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 1; i < 20; i++) begin
			if (x[i]) p = 5'(i);
		end
		return p;
	endfunction

	// One log2 fraction step on a Q31 mantissa in [1,2): square, truncate,
	// halve when >= 2. Returns {fraction bit, new mantissa}.
	function automatic logic [32:0] sq_step(input logic [31:0] m);
		logic [63:0] p;
		p = 64'(m) * 64'(m);
		if (p[63]) return {1'b1, p[63:32]};
		else return {1'b0, p[62:31]};
	endfunction

endpackage

`default_nettype wire

// ===== src/ntc_adc_to_temperature.sv =====
// Top level of the NTC thermistor converter: ADC code to centidegrees Celsius.
// Depends on ntcadc_pkg for constants, the register map and the log2 step.
`default_nettype none

// Usage:
//   s_* channel: one beat per ADC code (s_tdata holds adc_code in the low bits).
//   m_* channel: one beat per code, in order. m_tdata holds temp_centi_c
//   (signed, 0.01 C), m_tuser is the fault flag (open/short or a zero register).
//   cfg_* channel: cfg_index selects beta, pull-up, nominal ohms or nominal
//   centikelvin; cfg_ready is always high. Write registers only while no
//   code is in flight.
// Pipeline: a fully pipelined datapath of 64 register stages
// (32 log2 squaring stages, a 15-stage quotient divider at 4 bits per stage,
// a 9-stage reciprocal divider at 2 bits per stage and a few add/multiply
// stages) plus the output register. One code is accepted every cycle while
// s_tready is high, that is while the skid is empty and no rebuild runs.
// Reset and register writes: the constants derived from the registers
// (log2 of the resistor ratio and 1/T0) are rebuilt by a sequential unit,
// and s_tready stays low after reset or after any write until that unit is done.
// Stall: a one-beat skid stage sits behind the output register; the
// pipeline keeps running until both are full, then freezes as a whole.
module ntc_adc_to_temperature
	import ntcadc_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [((ADC_BITS+7)/8)*8-1:0] s_tdata,    // [ADC_BITS-1:0] adc_code
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [OUT_TDATA_W-1:0]       m_tdata,    // [18:0] temp_centi_c
	output logic                         m_tuser,    // [0] fault
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [CFG_IDX_W-1:0]         cfg_index,
	input  wire  [CFG_W-1:0]             cfg_data
);

	localparam int LOG_ST  = 32;
	localparam int QDIV_ST = 15;
	localparam int QDIV_BT = 4;
	localparam int QD_W    = QDIV_ST * QDIV_BT;
	localparam int TDIV_ST = 9;
	localparam int TDIV_BT = 2;
	localparam int TQ_W    = TDIV_ST * TDIV_BT;
	localparam int NST     = 1 + LOG_ST + 3 + QDIV_ST + 3 + TDIV_ST + 1;
	localparam int LS_W    = 42;
	localparam int MAG_W   = 40;
	localparam int LNM_W   = 41;
	localparam int IV0_W   = 56;
	localparam int INV_W   = 62;
	localparam int NP_W    = 61;
	localparam int TR_W    = INV_W - 1;
	localparam int CNT_W   = 6;
	localparam logic [CNT_W-1:0] CFG_DONE = CNT_W'(IV0_W + 1);
	localparam logic [IV0_W-1:0] HUNDRED_Q48 = IV0_W'(100) << 48;

	// ---------------- configuration and derived constants ----------------
	logic [13:0]          beta_q;
	logic [19:0]          pullup_q;
	logic [19:0]          nominal_q;
	logic [15:0]          nom_ck_q;
	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [31:0]          cp_m_q, cn_m_q, cp_f_q, cn_f_q;
	logic [4:0]           cp_e_q, cn_e_q;
	logic [IV0_W-1:0]     cd_n_q, cd_n_nx;
	logic [15:0]          cd_r_q, cd_r_nx;
	logic [LS_W-1:0]      lrat_q;
	logic [IV0_W-1:0]     inv0_q;
	logic [32:0]          cp_sq, cn_sq;
	logic                 cfg_bad;

	assign cfg_ready = 1'b1;
	assign cfg_bad = (beta_q == '0) || (pullup_q == '0) || (nominal_q == '0) ||
		(nom_ck_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q    <= BETA_RST;
			pullup_q  <= PULLUP_RST;
			nominal_q <= NOMINAL_RST;
			nom_ck_q  <= NOM_CK_RST;
			busy_q    <= 1'b1;
			cnt_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
			REG_BETA:    beta_q <= cfg_data[13:0];
			REG_PULLUP:  pullup_q <= cfg_data[19:0];
			REG_NOMINAL: nominal_q <= cfg_data[19:0];
			REG_NOM_CK:  nom_ck_q <= cfg_data[15:0];
			default:     beta_q <= beta_q;
			endcase
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CFG_DONE) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	assign cp_sq = sq_step(cp_m_q);
	assign cn_sq = sq_step(cn_m_q);

	always_comb begin : p_cdiv
		logic [16:0] rr;
		rr = {cd_r_q, cd_n_q[IV0_W-1]};
		cd_n_nx = {cd_n_q[IV0_W-2:0], 1'b0};
		if (rr >= 17'(nom_ck_q)) begin
			rr = rr - 17'(nom_ck_q);
			cd_n_nx[0] = 1'b1;
		end
		cd_r_nx = rr[15:0];
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (cnt_q == '0) begin
				cp_e_q <= msb_pos(pullup_q);
				cn_e_q <= msb_pos(nominal_q);
				cp_m_q <= 32'(pullup_q) << (5'd31 - msb_pos(pullup_q));
				cn_m_q <= 32'(nominal_q) << (5'd31 - msb_pos(nominal_q));
				cp_f_q <= '0;
				cn_f_q <= '0;
				cd_n_q <= HUNDRED_Q48 + IV0_W'(nom_ck_q[15:1]);
				cd_r_q <= '0;
			end else if (cnt_q == CFG_DONE) begin
				lrat_q <= LS_W'({cp_e_q, cp_f_q}) - LS_W'({cn_e_q, cn_f_q});
				inv0_q <= cd_n_q;
			end else begin
				cd_n_q <= cd_n_nx;
				cd_r_q <= cd_r_nx;
				if (cnt_q <= CNT_W'(LOG_ST)) begin
					cp_m_q <= cp_sq[31:0];
					cn_m_q <= cn_sq[31:0];
					cp_f_q <= {cp_f_q[30:0], cp_sq[32]};
					cn_f_q <= {cn_f_q[30:0], cn_sq[32]};
				end
			end
		end
	end

	// ---------------- handshake and stage valids ----------------
	logic [NST-1:0] stage_vld_q;
	logic           en, in_acc, take;
	logic           out_vld_q, sk_vld_q;
	logic signed [TEMP_W-1:0] out_temp_q, sk_temp_q;
	logic           out_flt_q, sk_flt_q;

	assign en       = !sk_vld_q;
	assign s_tready = en && !busy_q;
	assign in_acc   = s_tvalid && s_tready;
	assign take     = out_vld_q && m_tready;

	// ---------------- stage 1: range check and normalize ----------------
	logic [ADC_BITS-1:0] code, code_c;
	logic [4:0]          ea_in, eb_in;
	logic                flt_s1;
	logic [4:0]          ea_s1, eb_s1;
	logic [31:0]         ma_s1, mb_s1;

	assign code   = s_tdata[ADC_BITS-1:0];
	assign code_c = {ADC_BITS{1'b1}} - code;
	assign ea_in  = msb_pos(20'(code));
	assign eb_in  = msb_pos(20'(code_c));

	always_ff @(posedge clk) begin
		if (en) begin
			flt_s1 <= (code == '0) || (code == {ADC_BITS{1'b1}}) || cfg_bad;
			ea_s1  <= ea_in;
			eb_s1  <= eb_in;
			ma_s1  <= 32'(code) << (5'd31 - ea_in);
			mb_s1  <= 32'(code_c) << (5'd31 - eb_in);
		end
	end

	// ---------------- stages 2..33: log2 fraction bits ----------------
	logic [31:0] lg_ma_s2 [LOG_ST];
	logic [31:0] lg_mb_s2 [LOG_ST];
	logic [31:0] lg_fa_s2 [LOG_ST];
	logic [31:0] lg_fb_s2 [LOG_ST];
	logic [4:0]  lg_ea_s2 [LOG_ST];
	logic [4:0]  lg_eb_s2 [LOG_ST];
	logic        lg_flt_s2 [LOG_ST];
	logic [31:0] lg_ma_nx [LOG_ST];
	logic [31:0] lg_mb_nx [LOG_ST];
	logic [31:0] lg_fa_nx [LOG_ST];
	logic [31:0] lg_fb_nx [LOG_ST];

	always_comb begin : p_log
		logic [32:0] sa, sb;
		logic [31:0] fa, fb;
		for (int k = 0; k < LOG_ST; k++) begin
			if (k == 0) begin
				sa = sq_step(ma_s1);
				sb = sq_step(mb_s1);
				fa = '0;
				fb = '0;
			end else begin
				sa = sq_step(lg_ma_s2[k-1]);
				sb = sq_step(lg_mb_s2[k-1]);
				fa = lg_fa_s2[k-1];
				fb = lg_fb_s2[k-1];
			end
			lg_ma_nx[k] = sa[31:0];
			lg_mb_nx[k] = sb[31:0];
			lg_fa_nx[k] = {fa[30:0], sa[32]};
			lg_fb_nx[k] = {fb[30:0], sb[32]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lg_ma_s2 <= lg_ma_nx;
			lg_mb_s2 <= lg_mb_nx;
			lg_fa_s2 <= lg_fa_nx;
			lg_fb_s2 <= lg_fb_nx;
			lg_ea_s2[0]  <= ea_s1;
			lg_eb_s2[0]  <= eb_s1;
			lg_flt_s2[0] <= flt_s1;
			for (int k = 1; k < LOG_ST; k++) begin
				lg_ea_s2[k]  <= lg_ea_s2[k-1];
				lg_eb_s2[k]  <= lg_eb_s2[k-1];
				lg_flt_s2[k] <= lg_flt_s2[k-1];
			end
		end
	end

	// ---------------- stage 34: log ratio sum, sign and magnitude ----------------
	logic [LS_W-1:0]  lsum;
	logic             neg_s34, flt_s34;
	logic [MAG_W-1:0] mag_s34;

	assign lsum = lrat_q + LS_W'({lg_ea_s2[LOG_ST-1], lg_fa_s2[LOG_ST-1]})
		- LS_W'({lg_eb_s2[LOG_ST-1], lg_fb_s2[LOG_ST-1]});

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s34 <= lsum[LS_W-1];
			mag_s34 <= lsum[LS_W-1] ? MAG_W'(-lsum) : MAG_W'(lsum);
			flt_s34 <= lg_flt_s2[LOG_ST-1];
		end
	end

	// ---------------- stage 35: scale by ln 2 ----------------
	logic [63:0]      prod_lo;
	logic [39:0]      prod_hi;
	logic [LNM_W-1:0] lnm_s35;
	logic             neg_s35, flt_s35;

	assign prod_lo = 64'(mag_s34[31:0]) * 64'(LN2_Q32);
	assign prod_hi = 40'(mag_s34[MAG_W-1:32]) * 40'(LN2_Q32);

	always_ff @(posedge clk) begin
		if (en) begin
			lnm_s35 <= LNM_W'(prod_hi) + LNM_W'(prod_lo[63:32]);
			neg_s35 <= neg_s34;
			flt_s35 <= flt_s34;
		end
	end

	// ---------------- stage 36: rounded numerator for /beta ----------------
	logic [QD_W-1:0] nq_s36;
	logic            neg_s36, flt_s36;

	always_ff @(posedge clk) begin
		if (en) begin
			nq_s36  <= QD_W'({lnm_s35, 16'd0}) + QD_W'(beta_q[13:1]);
			neg_s36 <= neg_s35;
			flt_s36 <= flt_s35;
		end
	end

	// ---------------- stages 37..51: divide by beta ----------------
	logic [QD_W-1:0] qd_n_s37 [QDIV_ST];
	logic [13:0]     qd_r_s37 [QDIV_ST];
	logic            qd_neg_s37 [QDIV_ST];
	logic            qd_flt_s37 [QDIV_ST];
	logic [QD_W-1:0] qd_n_nx [QDIV_ST];
	logic [13:0]     qd_r_nx [QDIV_ST];

	always_comb begin : p_qdiv
		logic [QD_W-1:0] n;
		logic [13:0]     r;
		logic [14:0]     rr;
		for (int k = 0; k < QDIV_ST; k++) begin
			n = (k == 0) ? nq_s36 : qd_n_s37[(k == 0) ? 0 : k-1];
			r = (k == 0) ? 14'd0 : qd_r_s37[(k == 0) ? 0 : k-1];
			for (int j = 0; j < QDIV_BT; j++) begin
				rr = {r, n[QD_W-1]};
				n = {n[QD_W-2:0], 1'b0};
				if (rr >= 15'(beta_q)) begin
					rr = rr - 15'(beta_q);
					n[0] = 1'b1;
				end
				r = rr[13:0];
			end
			qd_n_nx[k] = n;
			qd_r_nx[k] = r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qd_n_s37 <= qd_n_nx;
			qd_r_s37 <= qd_r_nx;
			qd_neg_s37[0] <= neg_s36;
			qd_flt_s37[0] <= flt_s36;
			for (int k = 1; k < QDIV_ST; k++) begin
				qd_neg_s37[k] <= qd_neg_s37[k-1];
				qd_flt_s37[k] <= qd_flt_s37[k-1];
			end
		end
	end

	// ---------------- stage 52: 1/T = 1/T0 +- ln/beta ----------------
	logic [INV_W-1:0] inv_nx;
	logic [INV_W-1:0] inv_s52;
	logic             npos_s52, flt_s52;

	assign inv_nx = qd_neg_s37[QDIV_ST-1]
		? INV_W'(inv0_q) - INV_W'(qd_n_s37[QDIV_ST-1])
		: INV_W'(inv0_q) + INV_W'(qd_n_s37[QDIV_ST-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s52  <= inv_nx;
			npos_s52 <= inv_nx[INV_W-1] || (inv_nx == '0);
			flt_s52  <= qd_flt_s37[QDIV_ST-1];
		end
	end

	// ---------------- stage 53: rounded numerator for the reciprocal ----------------
	logic [NP_W-1:0] np_nx;
	logic [NP_W-1:0] np_s53;
	logic [TR_W-1:0] d_s53;
	logic            sat_s53, flt_s53;

	assign np_nx = NP_W'(HUNDRED_Q48) + NP_W'(inv_s52[INV_W-1:1]);

	always_ff @(posedge clk) begin
		if (en) begin
			np_s53  <= np_nx;
			d_s53   <= inv_s52[TR_W-1:0];
			sat_s53 <= npos_s52;
			flt_s53 <= flt_s52;
		end
	end

	// ---------------- stage 54: quotient overflow check ----------------
	logic [TR_W-1:0] r_s54, d_s54;
	logic [TQ_W-1:0] nlo_s54;
	logic            sat_s54, flt_s54;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s54   <= TR_W'(np_s53[NP_W-1:TQ_W]);
			nlo_s54 <= np_s53[TQ_W-1:0];
			d_s54   <= d_s53;
			sat_s54 <= sat_s53 || (TR_W'(np_s53[NP_W-1:TQ_W]) >= d_s53);
			flt_s54 <= flt_s53;
		end
	end

	// ---------------- stages 55..63: 100*2^48 / invT ----------------
	logic [TR_W-1:0] td_r_s55 [TDIV_ST];
	logic [TQ_W-1:0] td_n_s55 [TDIV_ST];
	logic [TR_W-1:0] td_d_s55 [TDIV_ST];
	logic            td_sat_s55 [TDIV_ST];
	logic            td_flt_s55 [TDIV_ST];
	logic [TR_W-1:0] td_r_nx [TDIV_ST];
	logic [TQ_W-1:0] td_n_nx [TDIV_ST];

	always_comb begin : p_tdiv
		logic [TR_W-1:0] r, d;
		logic [TQ_W-1:0] n;
		logic [TR_W:0]   rr;
		for (int k = 0; k < TDIV_ST; k++) begin
			r = (k == 0) ? r_s54 : td_r_s55[(k == 0) ? 0 : k-1];
			n = (k == 0) ? nlo_s54 : td_n_s55[(k == 0) ? 0 : k-1];
			d = (k == 0) ? d_s54 : td_d_s55[(k == 0) ? 0 : k-1];
			for (int j = 0; j < TDIV_BT; j++) begin
				rr = {r, n[TQ_W-1]};
				n = {n[TQ_W-2:0], 1'b0};
				if (rr >= (TR_W+1)'(d)) begin
					rr = rr - (TR_W+1)'(d);
					n[0] = 1'b1;
				end
				r = rr[TR_W-1:0];
			end
			td_r_nx[k] = r;
			td_n_nx[k] = n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			td_r_s55 <= td_r_nx;
			td_n_s55 <= td_n_nx;
			td_d_s55[0]   <= d_s54;
			td_sat_s55[0] <= sat_s54;
			td_flt_s55[0] <= flt_s54;
			for (int k = 1; k < TDIV_ST; k++) begin
				td_d_s55[k]   <= td_d_s55[k-1];
				td_sat_s55[k] <= td_sat_s55[k-1];
				td_flt_s55[k] <= td_flt_s55[k-1];
			end
		end
	end

	// ---------------- stage 64: Kelvin to Celsius, clamp, fault ----------------
	logic [TQ_W-1:0]          tck;
	logic signed [TEMP_W-1:0] temp_s64;
	logic                     flt_s64;

	assign tck = td_n_s55[TDIV_ST-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (td_flt_s55[TDIV_ST-1]) begin
				temp_s64 <= FAULT_TEMP;
			end else if (td_sat_s55[TDIV_ST-1] || (tck > TCK_MAX)) begin
				temp_s64 <= TEMP_MAX;
			end else begin
				temp_s64 <= $signed(TEMP_W'(tck) - TEMP_W'(ZERO_C_CK));
			end
			flt_s64 <= td_flt_s55[TDIV_ST-1];
		end
	end

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
			out_vld_q   <= 1'b0;
			sk_vld_q    <= 1'b0;
		end else begin
			if (en) stage_vld_q <= {stage_vld_q[NST-2:0], in_acc};
			if (sk_vld_q) begin
				if (!out_vld_q || take) begin
					out_vld_q <= 1'b1;
					sk_vld_q  <= 1'b0;
				end
			end else if (en && stage_vld_q[NST-1]) begin
				// park the beat in the skid when the output is held
				if (!out_vld_q || take) out_vld_q <= 1'b1;
				else sk_vld_q <= 1'b1;
			end else if (take) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sk_vld_q) begin
			if (!out_vld_q || take) begin
				out_temp_q <= sk_temp_q;
				out_flt_q  <= sk_flt_q;
			end
		end else if (en && stage_vld_q[NST-1]) begin
			if (!out_vld_q || take) begin
				out_temp_q <= temp_s64;
				out_flt_q  <= flt_s64;
			end else begin
				sk_temp_q <= temp_s64;
				sk_flt_q  <= flt_s64;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_TDATA_W-TEMP_W){1'b0}}, out_temp_q};
	assign m_tuser  = out_flt_q;

endmodule

`default_nettype wire

// ===== src/ntcadc_chk.sv =====
// Port-level checker for ntc_adc_to_temperature, bound to the top level.
// Depends on ntcadc_pkg for the result limits and port widths.
`default_nettype none

module ntcadc_chk
	import ntcadc_pkg::*;
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_tvalid,
	input wire                   s_tready,
	input wire                   m_tvalid,
	input wire                   m_tready,
	input wire [OUT_TDATA_W-1:0] m_tdata,
	input wire                   m_tuser,
	input wire                   cfg_valid,
	input wire                   cfg_ready
);

	// a faulted beat carries the fault marker value
	a_fault_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[TEMP_W-1:0] == FAULT_TEMP)
		else $error("fault beat without fault value");

	// a good beat lies between absolute zero and the clamp
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			$signed(m_tdata[TEMP_W-1:0]) >= TEMP_MIN &&
			$signed(m_tdata[TEMP_W-1:0]) <= TEMP_MAX)
		else $error("temperature out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:TEMP_W] == '0)
		else $error("tdata padding not zero");

	// a register write rebuilds the derived constants before new codes
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_tready)
		else $error("input accepted right after register write");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output beat changed");

endmodule

bind ntc_adc_to_temperature ntcadc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== bench/tb_ntc_adc_to_temperature.sv =====
// Self-checking bench for ntc_adc_to_temperature: ADC codes in, centidegrees out.
// Depends on ntcadc_pkg and the block; predicts results with a bit-exact model, except for pinned directed codes.
`default_nettype none

module tb_ntc_adc_to_temperature;
	import ntcadc_pkg::*;

	localparam int CODE_W   = 12;
	localparam int IN_W     = ((CODE_W + 7) / 8) * 8;
	localparam int LIMIT    = 600000;
	localparam int DRAIN    = 80;
	localparam int RAND_PER = 140;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     fault;
	} reading_t;

	typedef struct {
		logic [IN_W-1:0]          code;
		bit                       pinned;
		logic signed [TEMP_W-1:0] temp;
		logic                     fault;
	} code_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata;    // [11:0] adc_code
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;    // [18:0] temp_centi_c
	logic                   m_tuser;    // [0] fault
	logic                   cfg_valid;
	logic                   cfg_ready;
	cfg_reg_t               cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	ntc_adc_to_temperature uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Local copy of the register file
	logic [63:0] beta_k, pullup_r, nom_r, nom_ck;

	reading_t readings_due[$];
	int       fail_count;
	int       codes_sent;
	int       readings_seen;
	int       faults_seen;
	int       hot_seen;
	int       burst_left;
	int       cycle_count;
	bit       stall_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT) begin
				$display("timeout after %0d cycles, %0d readings pending",
					cycle_count, readings_due.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// log2 of x in unsigned Q32: leading-one position plus 32 squaring steps
	function automatic logic [63:0] log2_fix(input logic [63:0] x);
		logic [63:0] e, m, frac;
		e = 0;
		frac = 0;
		while (e < 31 && (x >> (e + 1)) != 0)
			e++;
		m = x << (31 - e);
		for (int i = 1; i <= 32; i++) begin
			m = (m * m) >> 31;
			if (m >= (64'd2 << 31)) begin
				m >>= 1;
				frac |= 64'd1 << (32 - i);
			end
		end
		return (e << 32) | frac;
	endfunction

	function automatic logic [63:0] rdiv(input logic [63:0] n, input logic [63:0] d);
		return (n + d / 2) / d;
	endfunction

	function automatic reading_t predict_temp(input logic [IN_W-1:0] raw);
		logic [63:0]        fs, c, mag, lnm, inv0, q, tck;
		logic signed [63:0] lsum, inv, t;
		reading_t           r;
		fs = (64'd1 << CODE_W) - 1;
		c = 64'(raw) & fs;
		if (c == 0 || c >= fs || beta_k == 0 || pullup_r == 0 || nom_r == 0 || nom_ck == 0) begin
			r.temp = FAULT_TEMP;
			r.fault = 1'b1;
			return r;
		end
		lsum = $signed(log2_fix(pullup_r)) + $signed(log2_fix(c))
			- $signed(log2_fix(fs - c)) - $signed(log2_fix(nom_r));
		mag = (lsum < 0) ? 64'(-lsum) : 64'(lsum);
		lnm = (mag >> 32) * 64'(LN2_Q32) + (((mag & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32);
		inv0 = rdiv(64'd100 << 48, nom_ck);
		q = rdiv(lnm << 16, beta_k);
		inv = (lsum < 0) ? $signed(inv0) - $signed(q) : $signed(inv0) + $signed(q);
		if (inv <= 0) begin
			t = 200000;
		end else begin
			tck = rdiv(64'd100 << 48, 64'(inv));
			t = (tck > 227315) ? 64'sd200000 : $signed(tck) - 27315;
		end
		r.temp = TEMP_W'(t);
		r.fault = 1'b0;
		return r;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BETA:    beta_k = 64'(val[13:0]);
			REG_PULLUP:  pullup_r = 64'(val);
			REG_NOMINAL: nom_r = 64'(val);
			REG_NOM_CK:  nom_ck = 64'(val[15:0]);
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] p,
		input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
		write_reg(REG_BETA, b);
		@(posedge clk);
		write_reg(REG_PULLUP, p);
		write_reg(REG_NOMINAL, n);
		write_reg(REG_NOM_CK, k);
	endtask

	// Offer one beat; bursts of random length separated by random gaps
	task automatic send_code(input logic [IN_W-1:0] raw, input bit pinned,
		input reading_t pin_val);
		if (burst_left == 0) begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		do @(posedge clk); while (!s_tready);
		readings_due.push_back(pinned ? pin_val : predict_temp(raw));
		codes_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] rand_code();
		logic [IN_W-1:0] v;
		int              sel;
		v = IN_W'($urandom);
		sel = $urandom_range(0, 15);
		// Mostly uniform codes; lean on the rails and their neighbors now and then
		case (sel)
			0: v[CODE_W-1:0] = '0;
			1: v[CODE_W-1:0] = '1;
			2: v[CODE_W-1:0] = CODE_W'($urandom_range(1, 8));
			3: v[CODE_W-1:0] = CODE_W'(4094 - $urandom_range(0, 7));
			default: begin
			end
		endcase
		return v;
	endfunction

	task automatic random_codes(input int n);
		reading_t none;
		none = '0;
		repeat (n) send_code(rand_code(), 1'b0, none);
	endtask

	// Receiver: one of four random stall patterns, plus one long hold-off
	initial begin
		int mode, stall_left;
		bit stall_taken;
		m_tready = 1'b0;
		mode = 0;
		stall_left = 0;
		stall_taken = 0;
		forever begin
			@(posedge clk);
			if (cycle_count % 128 == 0)
				mode = $urandom_range(0, 3);
			if (stall_req && !stall_taken) begin
				stall_taken = 1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Compare every output beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (readings_due.size() == 0) begin
				$error("unexpected output beat: temp=%0d fault=%0b",
					$signed(m_tdata[TEMP_W-1:0]), m_tuser);
				fail_count++;
			end else begin
				reading_t exp_r;
				exp_r = readings_due.pop_front();
				readings_seen++;
				if (exp_r.fault)
					faults_seen++;
				if (!exp_r.fault && exp_r.temp == TEMP_MAX)
					hot_seen++;
				if ($signed(m_tdata[TEMP_W-1:0]) != exp_r.temp) begin
					$error("temp_centi_c: expected %0d, got %0d", exp_r.temp,
						$signed(m_tdata[TEMP_W-1:0]));
					fail_count++;
				end
				if (m_tuser != exp_r.fault) begin
					$error("fault: expected %0b, got %0b", exp_r.fault, m_tuser);
					fail_count++;
				end
			end
		end
	end

	code_row_t directed[] = '{
		'{16'h0000, 1, FAULT_TEMP, 1'b1},
		'{16'h0FFF, 1, FAULT_TEMP, 1'b1},
		'{16'hF000, 1, FAULT_TEMP, 1'b1},
		'{16'hAFFF, 1, FAULT_TEMP, 1'b1},
		'{16'h0001, 0, '0, 1'b0},
		'{16'h0002, 0, '0, 1'b0},
		'{16'h0FFE, 0, '0, 1'b0},
		'{16'h0FFD, 0, '0, 1'b0},
		'{16'h0800, 0, '0, 1'b0},
		'{16'h07FF, 0, '0, 1'b0},
		'{16'h5800, 0, '0, 1'b0},
		'{16'h0555, 0, '0, 1'b0},
		'{16'h0AAA, 0, '0, 1'b0},
		'{16'h0100, 0, '0, 1'b0},
		'{16'h0F00, 0, '0, 1'b0},
		'{16'hFFFE, 0, '0, 1'b0}
	};

	initial begin
		reading_t pin;
		fail_count = 0;
		codes_sent = 0;
		readings_seen = 0;
		faults_seen = 0;
		hot_seen = 0;
		burst_left = 0;
		stall_req = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BETA;
		cfg_data = '0;
		beta_k = 64'(BETA_RST);
		pullup_r = 64'(PULLUP_RST);
		nom_r = 64'(NOMINAL_RST);
		nom_ck = 64'(NOM_CK_RST);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			pin.temp = directed[i].temp;
			pin.fault = directed[i].fault;
			send_code(directed[i].code, directed[i].pinned, pin);
		end
		random_codes(RAND_PER);

		// Sender pauses until everything is back, then the receiver holds off
		wait_idle();
		stall_req = 1;
		random_codes(RAND_PER);
		wait_idle();

		// Extremes: a too-hot corner, a deep-cold corner, all-ones, all-zeros
		set_regs(20'd1000, 20'd100, 20'd1000000, 20'd37315);
		random_codes(RAND_PER);
		wait_idle();
		set_regs(20'd10000, 20'd1000000, 20'd100, 20'd27315);
		random_codes(RAND_PER);
		wait_idle();
		set_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		random_codes(RAND_PER);
		wait_idle();
		set_regs(20'd0, 20'd0, 20'd0, 20'd0);
		random_codes(40);
		wait_idle();
		for (int z = 0; z < 4; z++) begin
			set_regs(20'd3435, 20'd10000, 20'd10000, 20'd29815);
			write_reg(cfg_reg_t'(z), '0);
			random_codes(25);
			wait_idle();
		end
		repeat (6) begin
			set_regs(CFG_W'($urandom_range(1000, 10000)), CFG_W'($urandom_range(100, 1000000)),
				CFG_W'($urandom_range(100, 1000000)), CFG_W'($urandom_range(27315, 37315)));
			random_codes(RAND_PER);
			wait_idle();
		end

		$display("run covered %0d codes over 15 register settings: %0d readings checked,",
			codes_sent, readings_seen);
		$display("  %0d fault readings, %0d saturated hot readings, %0d mismatches",
			faults_seen, hot_seen, fail_count);
		if (fail_count == 0 && readings_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire
